// File: src/ckx_pkg.sv
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared types, constants and lookup functions of the k-mer extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckx_pkg;

  localparam int unsigned SymW       = 5;    // symbol index width
  localparam int unsigned NumSym     = 20;   // largest alphabet
  localparam int unsigned LogW       = 31;   // log2 in q.28, up to log2(64)
  localparam int unsigned LogEntries = 65;   // log table covers 0..64
  localparam int unsigned LogFrac    = 28;

  localparam logic [7:0] ChHeader  = 8'h3E;  // '>'
  localparam logic [7:0] ChNewline = 8'h0A;

  localparam logic [2:0] RegWinLen = 3'd0;
  localparam logic [2:0] RegMode   = 3'd1;
  localparam logic [2:0] RegCanon  = 3'd2;
  localparam logic [2:0] RegFold   = 3'd3;
  localparam logic [2:0] RegEntLo  = 3'd4;
  localparam logic [2:0] RegEntHi  = 3'd5;

  typedef enum logic [1:0] {
    MODE_NUC   = 2'd0,
    MODE_RY    = 2'd1,
    MODE_AMINO = 2'd2
  } mode_e;

  typedef struct packed {
    logic [6:0]  k;       // clamped window length
    mode_e       mode;    // effective alphabet
    logic        canon;
    logic        fold;
    logic [16:0] lo;
    logic [16:0] hi;
  } cfg_t;

  typedef struct packed {
    logic            hit;
    logic [SymW-1:0] idx;
  } sym_t;

  typedef struct packed {
    logic [63:0] kmer;
    logic [3:0]  nbytes;
    logic        rev;
    logic [31:0] count;
  } result_t;

  typedef logic [LogW-1:0] log_tbl_t [LogEntries];

  // integer squaring log2, only evaluated at elaboration
  function automatic logic [LogW-1:0] log2_q28(int unsigned n);
    logic [63:0]     y;
    logic [LogW-1:0] r;
    int unsigned     ip;
    ip = 0;
    if (n == 0) return '0;
    for (int p = 1; p <= 30; p++) begin
      if ((n >> p) != 0) ip = p;
    end
    y = 64'(n) << (30 - ip);
    r = LogW'(ip) << LogFrac;
    for (int b = LogFrac; b > 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r[b-1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tbl_t build_log_tbl();
    log_tbl_t t;
    for (int i = 0; i < LogEntries; i++) t[i] = log2_q28(i);
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();

  function automatic mode_e eff_mode(logic [1:0] m);
    mode_e r;
    unique case (m)
      2'd1:    r = MODE_RY;
      2'd2:    r = MODE_AMINO;
      default: r = MODE_NUC;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] alpha_size(mode_e m);
    logic [4:0] r;
    unique case (m)
      MODE_RY:    r = 5'd2;
      MODE_AMINO: r = 5'd20;
      default:    r = 5'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] alpha_bits(mode_e m);
    logic [2:0] r;
    unique case (m)
      MODE_RY:    r = 3'd2;
      MODE_AMINO: r = 3'd5;
      default:    r = 3'd3;
    endcase
    return r;
  endfunction

  function automatic sym_t classify(logic [7:0] ch, mode_e m);
    sym_t s;
    s = '0;
    s.hit = 1'b1;
    unique case (m)
      MODE_RY: begin
        unique case (ch)
          "R":     s.idx = 5'd0;
          "Y":     s.idx = 5'd1;
          default: s.hit = 1'b0;
        endcase
      end
      MODE_AMINO: begin
        unique case (ch)
          "G": s.idx = 5'd0;   "A": s.idx = 5'd1;   "S": s.idx = 5'd2;
          "T": s.idx = 5'd3;   "C": s.idx = 5'd4;   "V": s.idx = 5'd5;
          "L": s.idx = 5'd6;   "I": s.idx = 5'd7;   "M": s.idx = 5'd8;
          "P": s.idx = 5'd9;   "F": s.idx = 5'd10;  "Y": s.idx = 5'd11;
          "W": s.idx = 5'd12;  "D": s.idx = 5'd13;  "E": s.idx = 5'd14;
          "N": s.idx = 5'd15;  "Q": s.idx = 5'd16;  "H": s.idx = 5'd17;
          "K": s.idx = 5'd18;  "R": s.idx = 5'd19;
          default: s.hit = 1'b0;
        endcase
      end
      default: begin
        unique case (ch)
          "A":     s.idx = 5'd0;
          "G":     s.idx = 5'd1;
          "C":     s.idx = 5'd2;
          "T":     s.idx = 5'd3;
          default: s.hit = 1'b0;
        endcase
      end
    endcase
    return s;
  endfunction

  // letter of a nucleotide-mode symbol, for the canonical compare
  function automatic logic [7:0] nuc_letter(mode_e m, logic [SymW-1:0] idx);
    logic [7:0] r;
    if (m == MODE_RY) begin
      r = (idx == 5'd0) ? "R" : "Y";
    end else begin
      unique case (idx[1:0])
        2'd0: r = "A";
        2'd1: r = "G";
        2'd2: r = "C";
        default: r = "T";
      endcase
    end
    return r;
  endfunction

endpackage

// File: src/ckx_queue.sv
// ----------------------------------------------------------------------------
// ckx_queue
// Two-entry queue that carries full windows from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckx_queue #(
  parameter int unsigned WIDTH = 160
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= 2'(cnt_q + {1'b0, wr_i} - {1'b0, rd_i});
    end
  end

endmodule

// File: src/ckx_front.sv
// ----------------------------------------------------------------------------
// ckx_front
// Byte parser and sliding symbol window; one byte per cycle while take_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckx_front
  import ckx_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic [7:0]                           char_i,
  input  cfg_t                                 cfg_i,
  input  logic                                 clr_i,
  output logic                                 enq_o,
  output logic [MAX_WINDOW-1:0][SymW-1:0]      win_o
);

  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);

  logic [MAX_WINDOW-1:0][SymW-1:0] win_q, win_d;
  logic [FW-1:0]                   fill_q, fill_d;
  logic                            hdr_q, hdr_d;
  logic [7:0]                      ch;
  logic [FW-1:0]                   nf;
  sym_t                            sym;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    hdr_d  = hdr_q;
    enq_o  = 1'b0;
    ch     = char_i;
    if (cfg_i.fold && ch >= "a" && ch <= "z") ch = 8'(ch - 8'd32);
    if (cfg_i.mode == MODE_RY) begin
      if (ch == "A" || ch == "G") ch = "R";
      else if (ch == "C" || ch == "T") ch = "Y";
    end
    sym = classify(ch, cfg_i.mode);
    nf  = (int'(fill_q) < MAX_WINDOW) ? FW'(fill_q + 1'b1) : fill_q;
    win_d = {sym.idx, win_q[MAX_WINDOW-1:1]};
    if (!take_i) begin
      win_d = win_q;
    end else if (char_i == ChHeader) begin
      hdr_d  = 1'b1;
      fill_d = '0;
      win_d  = win_q;
    end else if (hdr_q) begin
      if (char_i == ChNewline) hdr_d = 1'b0;
      win_d = win_q;
    end else if (char_i == ChNewline) begin
      win_d = win_q;
    end else if (!sym.hit) begin
      fill_d = '0;
      win_d  = win_q;
    end else if (cfg_i.k != 7'd0 && 7'(nf) >= cfg_i.k) begin
      fill_d = FW'(cfg_i.k - 7'd1);
      enq_o  = 1'b1;
    end else begin
      fill_d = nf;
    end
    if (clr_i) fill_d = '0;
  end

  assign win_o = win_d;

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hdr_q  <= 1'b0;
    end else begin
      fill_q <= fill_d;
      hdr_q  <= hdr_d;
    end
  end

endmodule

// File: src/ckx_back.sv
// ----------------------------------------------------------------------------
// ckx_back
// Window evaluation: count, canonical pick, packing, entropy and filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ckx_back
  import ckx_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 32,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [MAX_WINDOW-1:0][SymW-1:0] win_i,
  input  logic                            win_valid_i,
  output logic                            win_pop_o,
  input  cfg_t                            cfg_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output result_t                         res_o
);

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SUM, ST_NUM, ST_DIV, ST_CHECK, ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [MAX_WINDOW-1:0][SymW-1:0] fwd_q, bwd_q;
  logic [CW-1:0]                   cnt_q [NumSym];
  logic [6:0]                      i_q;
  logic [4:0]                      j_q;
  logic                            decided_q, rev_q;
  logic [63:0]                     vf_q, vr_q;
  logic [LogW-1:0]                 lk_q;
  logic [39:0]                     d_q, s_q;
  logic [57:0]                     rem_q, dsh_q;
  logic [18:0]                     q_q;
  logic [31:0]                     hit_q;
  result_t                         res_q;

  logic [SymW-1:0] f, r, rc;
  logic [4:0]      top;
  logic [2:0]      bps;
  logic [63:0]     mask;
  logic            canon_act;
  logic [CW-1:0]   c;
  logic [37:0]     term;
  logic [8:0]      bits;
  logic [5:0]      nb;
  logic [2:0]      pad;
  logic [16:0]     ent;
  logic [63:0]     v;

  always_comb begin
    f         = fwd_q[0];
    r         = bwd_q[MAX_WINDOW-1];
    top       = 5'(alpha_size(cfg_i.mode) - 5'd1);
    rc        = 5'(top - r);
    bps       = alpha_bits(cfg_i.mode);
    mask      = (64'd1 << bps) - 64'd1;
    canon_act = cfg_i.canon && (cfg_i.mode != MODE_AMINO);
    c         = cnt_q[j_q];
    term      = 38'(c) * 38'(lk_q - LOG_TBL[7'(c)]);
    bits      = 9'(bps) * 9'(cfg_i.k);
    nb        = 6'((10'(bits) + 10'd7) >> 3);
    pad       = 3'(3'd0 - bits[2:0]);
    ent       = (q_q > 19'd65536) ? 17'h10000 : q_q[16:0];
    v         = rev_q ? vr_q : vf_q;
    v         = (v << pad) | ((64'd1 << pad) - 64'd1);
  end

  assign win_pop_o   = (state_q == ST_IDLE) && win_valid_i;
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        fwd_q     <= win_i >> (SymW * (MAX_WINDOW - int'(cfg_i.k)));
        bwd_q     <= win_i;
        vf_q      <= '0;
        vr_q      <= '0;
        decided_q <= 1'b0;
        rev_q     <= 1'b0;
        lk_q      <= LOG_TBL[cfg_i.k];
        d_q       <= 40'(cfg_i.k) * 40'(LOG_TBL[7'(alpha_size(cfg_i.mode))]);
        s_q       <= '0;
        for (int n = 0; n < NumSym; n++) cnt_q[n] <= '0;
      end
      ST_SCAN: begin
        fwd_q <= fwd_q >> SymW;
        bwd_q <= bwd_q << SymW;
        if (f < 5'(NumSym)) cnt_q[f] <= CW'(cnt_q[f] + 1'b1);
        if (canon_act && !decided_q &&
            nuc_letter(cfg_i.mode, f) != nuc_letter(cfg_i.mode, rc)) begin
          decided_q <= 1'b1;
          rev_q     <= nuc_letter(cfg_i.mode, f) > nuc_letter(cfg_i.mode, rc);
        end
        vf_q <= (vf_q << bps) | (64'(5'(f + 5'd1)) & mask);
        vr_q <= (vr_q << bps) | (64'(5'(rc + 5'd1)) & mask);
      end
      ST_SUM: begin
        s_q <= s_q + 40'(term);
      end
      ST_NUM: begin
        rem_q <= (58'(s_q) << 16) + 58'(d_q >> 1);
        dsh_q <= 58'(d_q) << 18;
        q_q   <= '0;
      end
      ST_DIV: begin
        if (rem_q >= dsh_q) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= {q_q[17:0], rem_q >= dsh_q};
      end
      ST_CHECK: begin
        res_q.kmer   <= v;
        res_q.nbytes <= nb[3:0];
        res_q.rev    <= rev_q;
        res_q.count  <= (hit_q == 32'hFFFF_FFFF) ? hit_q : 32'(hit_q + 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      hit_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          if (win_valid_i) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          i_q <= 7'(i_q + 1'b1);
          j_q <= '0;
          if (i_q == 7'(cfg_i.k - 7'd1)) state_q <= ST_SUM;
        end
        ST_SUM: begin
          j_q <= 5'(j_q + 1'b1);
          if (j_q == 5'(NumSym - 1)) state_q <= ST_NUM;
        end
        ST_NUM: begin
          j_q     <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          j_q <= 5'(j_q + 1'b1);
          if (j_q == 5'd18) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (ent >= cfg_i.lo && ent <= cfg_i.hi && int'(nb) * 8 <= KEY_BITS)
            state_q <= ST_EMIT;
          else
            state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            hit_q   <= res_q.count;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/canonical_kmer_extractor_unit.sv
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_unit
// FASTA byte stream in, entropy-filtered canonical k-mers out.
// ----------------------------------------------------------------------------
// usage:
//   input queue: one FASTA byte per request on char_in_i, taken when push is
//     high and full is low; the front takes one byte per cycle
//   result queue: while empty is low the oldest k-mer sits on the result
//     ports, popped when pop is high
//   apb port: six registers at byte offsets 0x00..0x14, write only while idle
// back end and window queue:
//   each full window passes the back end through load, k scan steps, 20
//   entropy-sum steps over the symbol counters, numerator, 19 restoring
//   divide steps, check and hand-off; a new window is taken only in idle.
//   bytes that do not complete a window never reach the back end
//   a two-deep window queue sits between front and back; full rises while
//   both entries wait
// reset: window empty, header flag and hit counter cleared, registers at
//   their defaults; result register empty
// receiver stall: a result holds in the output register, the back end waits
//   behind it and the front keeps taking bytes until the window queue fills
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module canonical_kmer_extractor_unit
  import ckx_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 32,
  parameter int unsigned KEY_BITS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [63:0] packed_kmer_o,
  output logic [3:0]  kmer_bytes_o,
  output logic        used_reverse_o,
  output logic [31:0] accepted_count_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned WinW = MAX_WINDOW * SymW;

  // configuration registers
  logic [5:0]  wlen_q;
  logic [1:0]  mode_q;
  logic        canon_q, fold_q;
  logic [16:0] lo_q, hi_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  cfg_t        cfg;

  // datapath links
  logic                            take;
  logic                            enq, q_full, q_valid, q_pop;
  logic [MAX_WINDOW-1:0][SymW-1:0] front_win, back_win;
  logic [WinW-1:0]                 q_rdata;
  logic                            back_valid, back_ready;
  result_t                         back_res;

  // output register
  logic    out_valid_q;
  result_t out_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegWinLen: prdata = 32'(wlen_q);
      RegMode:   prdata = 32'(mode_q);
      RegCanon:  prdata = 32'(canon_q);
      RegFold:   prdata = 32'(fold_q);
      RegEntLo:  prdata = 32'(lo_q);
      RegEntHi:  prdata = 32'(hi_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q  <= 6'd10;
      mode_q  <= 2'd0;
      canon_q <= 1'b1;
      fold_q  <= 1'b0;
      lo_q    <= 17'd0;
      hi_q    <= 17'h10000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWinLen: wlen_q  <= pwdata[5:0];
        RegMode:   mode_q  <= pwdata[1:0];
        RegCanon:  canon_q <= pwdata[0];
        RegFold:   fold_q  <= pwdata[0];
        RegEntLo:  lo_q    <= pwdata[16:0];
        RegEntHi:  hi_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // clamp window length to the window storage, fold reserved mode onto AGCT
  always_comb begin
    cfg.k     = (int'(wlen_q) > MAX_WINDOW) ? 7'(MAX_WINDOW) : 7'(wlen_q);
    cfg.mode  = eff_mode(mode_q);
    cfg.canon = canon_q;
    cfg.fold  = fold_q;
    cfg.lo    = lo_q;
    cfg.hi    = hi_q;
  end

  // a byte is taken whenever the window queue has room
  assign full = q_full;
  assign take = push && !full;

  ckx_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (char_in_i),
    .cfg_i  (cfg),
    .clr_i  (cfg_wr && (reg_idx == RegWinLen || reg_idx == RegMode)),
    .enq_o  (enq),
    .win_o  (front_win)
  );

  ckx_queue #(
    .WIDTH (WinW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (enq),
    .wdata_i (front_win),
    .rd_i    (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .valid_o (q_valid)
  );

  assign back_win = q_rdata;

  ckx_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .KEY_BITS   (KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (back_win),
    .win_valid_i (q_valid),
    .win_pop_o   (q_pop),
    .cfg_i       (cfg),
    .res_valid_o (back_valid),
    .res_ready_i (back_ready),
    .res_o       (back_res)
  );

  // output register parts the back end from the receiver
  assign back_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i) begin
    if (back_valid && back_ready) out_q <= back_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (back_valid && back_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty            = !out_valid_q;
  assign packed_kmer_o    = out_q.kmer;
  assign kmer_bytes_o     = out_q.nbytes;
  assign used_reverse_o   = out_q.rev;
  assign accepted_count_o = out_q.count;

  // a waiting result always carries a legal byte count
  a_bytes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kmer_bytes_o >= 4'd1 && kmer_bytes_o <= 4'd8))
    else $error("kmer byte count out of range");

  // every delivered result has been counted
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> accepted_count_o != 32'd0)
    else $error("result with zero accepted count");

  // the back end holds its result while the output register is busy
  a_back_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_valid && !back_ready |=> back_valid)
    else $error("back end dropped a stalled result");

endmodule

// File: tb/kmer_checker.sv
// ----------------------------------------------------------------------------
// kmer_checker
// Watches the byte, result and register ports of the k-mer extractor. It
// predicts each k-mer from the accepted bytes, then checks every popped
// result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmer_checker
  import ckx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_in_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] packed_kmer_o,
  input  logic [3:0]  kmer_bytes_o,
  input  logic        used_reverse_o,
  input  logic [31:0] accepted_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  // register copies
  logic [5:0]  win_len;
  logic [1:0]  mode_reg;
  logic        canon_en;
  logic        fold_en;
  logic [16:0] ent_lo;
  logic [16:0] ent_hi;

  // stream state
  logic [4:0]  win_syms [32];
  int unsigned win_fill;
  logic        in_hdr;
  logic [31:0] hit_total;

  result_t expected_kmers[$];

  assign pending = expected_kmers.size();

  function automatic byte unsigned sym_letter(mode_e m, int unsigned i);
    string s;
    case (m)
      MODE_RY:    s = "RY";
      MODE_AMINO: s = "GASTCVLIMPFYWDENQHKR";
      default:    s = "AGCT";
    endcase
    return s[i];
  endfunction

  function automatic longint unsigned log2_fix(int unsigned n);
    int unsigned     ip;
    longint unsigned y;
    longint unsigned r;
    if (n == 0) return 0;
    ip = 0;
    while (ip < 30 && (n >> (ip + 1)) != 0) ip++;
    y = longint'(n) << (30 - ip);
    r = longint'(ip) << 28;
    for (int b = 28; b > 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r = r | (64'd1 << (b - 1));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_kmer(input logic [7:0] ch_in);
    logic [7:0]      ch;
    mode_e           m;
    int unsigned     asize, bps, idx, k, base, bits, nbytes, pad;
    bit              found, rev;
    int unsigned     counts [20];
    longint unsigned lk, s, d, e;
    logic [63:0]     v;
    byte unsigned    fc, rc;
    int unsigned     sym;
    result_t         res;
    ch = ch_in;
    m = (mode_reg == 2'd1) ? MODE_RY : (mode_reg == 2'd2) ? MODE_AMINO : MODE_NUC;
    asize = (m == MODE_RY) ? 2 : (m == MODE_AMINO) ? 20 : 4;
    bps = (m == MODE_RY) ? 2 : (m == MODE_AMINO) ? 5 : 3;
    if (ch == ChHeader) begin
      in_hdr = 1'b1;
      win_fill = 0;
      return;
    end
    if (in_hdr) begin
      if (ch == ChNewline) in_hdr = 1'b0;
      return;
    end
    if (ch == ChNewline) return;
    if (fold_en && ch >= "a" && ch <= "z") ch = ch - 8'd32;
    if (m == MODE_RY) begin
      if (ch == "A" || ch == "G") ch = "R";
      else if (ch == "C" || ch == "T") ch = "Y";
    end
    found = 0;
    idx = 0;
    for (int unsigned i = 0; i < asize; i++) begin
      if (!found && sym_letter(m, i) == ch) begin
        found = 1;
        idx = i;
      end
    end
    if (!found) begin
      win_fill = 0;
      return;
    end
    for (int i = 0; i < 31; i++) win_syms[i] = win_syms[i+1];
    win_syms[31] = idx[4:0];
    if (win_fill < 32) win_fill++;

    k = win_len;
    if (k == 0) return;
    if (k > 32) k = 32;
    if (win_fill < k) return;
    win_fill = k - 1;
    base = 32 - k;

    // normalized entropy, q1.16
    foreach (counts[i]) counts[i] = 0;
    for (int unsigned i = 0; i < k; i++) counts[win_syms[base+i]]++;
    lk = log2_fix(k);
    s = 0;
    foreach (counts[i]) begin
      if (counts[i] != 0) s += longint'(counts[i]) * (lk - log2_fix(counts[i]));
    end
    d = longint'(k) * log2_fix(asize);
    e = (s * 65536 + d / 2) / d;
    if (e > 65536) e = 65536;
    if (e < ent_lo || e > ent_hi) return;

    bits = bps * k;
    nbytes = (bits + 7) / 8;
    if (nbytes * 8 > 64) return;   // key too wide, silently dropped
    pad = nbytes * 8 - bits;

    rev = 0;
    if (m != MODE_AMINO && canon_en) begin
      for (int unsigned i = 0; i < k; i++) begin
        fc = sym_letter(m, win_syms[base+i]);
        rc = sym_letter(m, asize - 1 - win_syms[base+k-1-i]);
        if (fc != rc) begin
          rev = fc > rc;
          break;
        end
      end
    end
    v = '0;
    for (int unsigned i = 0; i < k; i++) begin
      sym = rev ? asize - 1 - win_syms[base+k-1-i] : win_syms[base+i];
      v = (v << bps) | 64'((sym + 1) & ((1 << bps) - 1));
    end
    if (pad != 0) v = (v << pad) | ((64'd1 << pad) - 1);
    if (hit_total != 32'hFFFF_FFFF) hit_total++;

    res.kmer   = v;
    res.nbytes = nbytes[3:0];
    res.rev    = rev;
    res.count  = hit_total;
    expected_kmers.insert(expected_kmers.size(), res);
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      win_len   = 6'd10;
      mode_reg  = 2'd0;
      canon_en  = 1'b1;
      fold_en   = 1'b0;
      ent_lo    = 17'd0;
      ent_hi    = 17'd65536;
      foreach (win_syms[i]) win_syms[i] = '0;
      win_fill  = 0;
      in_hdr    = 1'b0;
      hit_total = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegWinLen: begin win_len = pwdata[5:0]; win_fill = 0; end
          RegMode:   begin mode_reg = pwdata[1:0]; win_fill = 0; end
          RegCanon:  canon_en = pwdata[0];
          RegFold:   fold_en = pwdata[0];
          RegEntLo:  ent_lo = pwdata[16:0];
          RegEntHi:  ent_hi = pwdata[16:0];
          default: ;
        endcase
      end
      if (push && !full) predict_kmer(char_in_i);
      if (pop && !empty) begin
        if (expected_kmers.size() == 0) begin
          report_mismatch("unexpected result", packed_kmer_o, 64'd0);
        end else begin
          want = expected_kmers.pop_front();
          if (packed_kmer_o !== want.kmer)
            report_mismatch("packed_kmer", packed_kmer_o, want.kmer);
          if (kmer_bytes_o !== want.nbytes)
            report_mismatch("kmer_bytes", 64'(kmer_bytes_o), 64'(want.nbytes));
          if (used_reverse_o !== want.rev)
            report_mismatch("used_reverse", 64'(used_reverse_o), 64'(want.rev));
          if (accepted_count_o !== want.count)
            report_mismatch("accepted_count", 64'(accepted_count_o), 64'(want.count));
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression for the canonical k-mer extractor. It sends FASTA-like byte
// streams over a range of register settings, with bursty input, random result
// stalls and one long stall. A checker beside the block scores the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ckx_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] packed_kmer_o;
  logic [3:0]  kmer_bytes_o;
  logic        used_reverse_o;
  logic [31:0] accepted_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // stimulus side bookkeeping
  int          burst_left = 0;
  logic        long_hold = 1'b0;
  logic        hold_trigger = 1'b0;
  logic [1:0]  cur_mode = 2'd0;
  logic        cur_fold = 1'b0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  canonical_kmer_extractor_unit dut (.*);

  kmer_checker u_checker (.*);

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("canonical_kmer_extractor_unit regression: fail");
      $finish;
    end
  end

  // result side: stall rate steps through four settings in turn, zero included
  always @(posedge clk_i) begin
    int unsigned rate;
    rate = 0;
    if (cycle_count % 256 == 0) rate = 0;
    case ((cycle_count / 256) % 4)
      0: rate = 0;
      1: rate = 30;
      2: rate = 70;
      default: rate = 10;
    endcase
    pop <= !long_hold && ($urandom_range(99) >= rate);
  end

  // long receiver hold-off so the window queue backs up into full
  initial begin
    @(posedge hold_trigger);
    long_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // one byte request, with bursts and gaps in front of it
  task automatic send_char(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    push <= 1'b1;
    char_in_i <= b;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // stop sending and let the back end settle before a register write
  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int k, input int m, input int cn, input int fl,
                          input int lo, input int hi);
    wait_idle();
    apb_write(RegWinLen, k);
    apb_write(RegMode, m);
    apb_write(RegCanon, cn);
    apb_write(RegFold, fl);
    apb_write(RegEntLo, lo);
    apb_write(RegEntHi, hi);
    cur_mode = m[1:0];
    cur_fold = fl[0];
  endtask

  // a sequence letter valid somewhere in the current alphabet
  function automatic logic [7:0] pick_letter();
    string       s;
    logic [7:0]  c;
    case (cur_mode)
      2'd1:    s = "ACGTRY";
      2'd2:    s = "GASTCVLIMPFYWDENQHKR";
      default: s = "AGCT";
    endcase
    c = s[$urandom_range(s.len() - 1)];
    if ($urandom_range(99) < (cur_fold ? 35 : 5)) c = c + 8'd32;
    return c;
  endfunction

  // random fasta text: mostly sequence in runs, some headers and noise
  task automatic send_fasta(input int n);
    int          sent;
    int          run;
    int unsigned r;
    logic [7:0]  c;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_char(ChHeader);
        run = $urandom_range(0, 6);
        for (int i = 0; i < run; i++) begin
          c = 8'($urandom_range(255));
          send_char((c == ChNewline) ? 8'h20 : c);
        end
        send_char(ChNewline);
        sent += run + 2;
      end else if (r < 8) begin
        send_char(ChNewline);
        sent++;
      end else if (r < 11) begin
        send_char(8'($urandom_range(255)));
        sent++;
      end else begin
        // long runs of one letter pull the entropy down
        c = pick_letter();
        run = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : 1;
        for (int i = 0; i < run; i++) send_char(c);
        sent += run;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: header restart, newline in sequence, case, byte extremes
    send_text(">h>x\nACGTACGTAC\nGTTacgtNTTTTTT");
    send_char(8'h00);
    send_char(8'hFF);

    set_regs(10, 0, 1, 0, 0, 65536);
    hold_trigger <= 1'b1;
    send_fasta(150);
    set_regs(1, 0, 1, 0, 0, 65536);
    send_fasta(60);
    set_regs(32, 1, 1, 1, 0, 65536);    // longest window in ry code
    send_fasta(120);
    set_regs(21, 0, 0, 1, 30000, 60000);
    send_fasta(120);
    set_regs(22, 0, 1, 0, 0, 65536);    // key too wide, nothing out
    send_fasta(50);
    set_regs(12, 2, 1, 1, 0, 65536);    // amino, largest key that fits
    send_fasta(120);
    set_regs(13, 2, 0, 0, 0, 65536);
    send_fasta(40);
    set_regs(0, 0, 1, 0, 0, 65536);     // zero length
    send_fasta(40);
    set_regs(63, 1, 1, 0, 0, 65536);    // clamps to the largest window
    send_fasta(120);
    set_regs(8, 3, 1, 1, 40000, 20000); // bounds crossed, all rejected
    send_fasta(40);
    set_regs(5, 3, 1, 0, 65536, 65536); // reserved mode, full entropy only
    send_fasta(120);
    set_regs(6, 0, 1, 1, 0, 0);
    send_fasta(120);
    set_regs(16, 1, 0, 0, 20000, 65535);
    send_fasta(120);
    set_regs(4, 0, 1, 1, 0, 65536);
    send_fasta(130);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("canonical_kmer_extractor_unit regression: pass");
    end else begin
      $display("canonical_kmer_extractor_unit regression: fail");
    end
    $finish;
  end

endmodule
